[rtl/mlpsf_pkg.sv]
// ----------------------------------------------------------------------------
// mlpsf_pkg
// Shared types, constants and the sigmoid table for the perceptron block.
// ----------------------------------------------------------------------------
package mlpsf_pkg;

    localparam int ACC_W = 40;

    typedef enum logic [2:0] {
        REG_INPUT_COUNT  = 3'd0,
        REG_HIDDEN_COUNT = 3'd1,
        REG_OUTPUT_COUNT = 3'd2,
        REG_WEIGHT_LOW   = 3'd3,
        REG_WEIGHT_HIGH  = 3'd4
    } reg_idx_t;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD_MUL,
        ST_LOAD_DIV,
        ST_LOAD_WR,
        ST_BIAS_RD,
        ST_BIAS_WAIT,
        ST_MAC_RD,
        ST_MAC_WAIT,
        ST_MAC_MUL,
        ST_MAC_ACC,
        ST_SIG_A,
        ST_SIG_B,
        ST_SIG_C
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load_mul;
        logic load_div;
        logic load_wr;
        logic sample_wr;
        logic bias_load;
        logic mac_mul;
        logic mac_acc;
        logic sig_a;
        logic sig_b;
        logic sig_c;
        logic hid_wr;
        logic out_strobe;
        logic out_last;
        logic layer;     // 0 hidden, 1 output
    } ctrl_t;

    function automatic logic [15:0] sig_lut(input logic [5:0] i);
        logic [15:0] r;
        case (i)
            6'd0: r = 16'd22;       6'd1: r = 16'd36;
            6'd2: r = 16'd60;       6'd3: r = 16'd98;
            6'd4: r = 16'd162;      6'd5: r = 16'd267;
            6'd6: r = 16'd439;      6'd7: r = 16'd720;
            6'd8: r = 16'd1179;     6'd9: r = 16'd1921;
            6'd10: r = 16'd3108;    6'd11: r = 16'd4971;
            6'd12: r = 16'd7812;    6'd13: r = 16'd11955;
            6'd14: r = 16'd17626;   6'd15: r = 16'd24743;
            6'd16: r = 16'd32768;   6'd17: r = 16'd40793;
            6'd18: r = 16'd47910;   6'd19: r = 16'd53581;
            6'd20: r = 16'd57724;   6'd21: r = 16'd60565;
            6'd22: r = 16'd62428;   6'd23: r = 16'd63615;
            6'd24: r = 16'd64357;   6'd25: r = 16'd64816;
            6'd26: r = 16'd65097;   6'd27: r = 16'd65269;
            6'd28: r = 16'd65374;   6'd29: r = 16'd65438;
            6'd30: r = 16'd65476;   6'd31: r = 16'd65500;
            6'd32: r = 16'd65514;
            default: r = 16'd65514;
        endcase
        return r;
    endfunction

endpackage

[rtl/mlp_sigmoid_forward_pass.sv]
// A weight load steps through the LOAD_MUL, LOAD_DIV and LOAD_WR states; a
// sample that does not complete the vector is only buffered; the completing
// sample starts a pass over the one MAC and weight RAM port.
// Results appear one per output unit, each strobed for one cycle via done;
// the receiver cannot stall. busy is high during all work; rst_n clears
// control state, the configuration registers and done.
// ----------------------------------------------------------------------------
// mlp_sigmoid_forward_pass
// Two-layer sigmoid perceptron, one shared MAC, weight RAM and sequencer.
// ----------------------------------------------------------------------------
module mlp_sigmoid_forward_pass #(
    parameter int MAX_INPUTS   = 16,
    parameter int MAX_HIDDEN   = 16,
    parameter int MAX_OUTPUTS  = 8,
    parameter int WEIGHT_DEPTH = 512
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cmd,
    input  logic [8:0]  weight_index,
    input  logic [7:0]  weight_byte,
    input  logic [15:0] sample,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output logic        done,
    output logic [15:0] out_value,
    output logic [2:0]  out_index,
    output logic        out_last
);
    import mlpsf_pkg::*;

    logic [4:0]  input_count_reg, hidden_count_reg;
    logic [3:0]  output_count_reg;
    logic signed [15:0] weight_low_reg, weight_high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_count_reg  <= 5'd16;
            hidden_count_reg <= 5'd16;
            output_count_reg <= 4'd8;
            weight_low_reg   <= -16'sd256;
            weight_high_reg  <= 16'sd256;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_INPUT_COUNT:  input_count_reg  <= cfg_data[4:0];
                REG_HIDDEN_COUNT: hidden_count_reg <= cfg_data[4:0];
                REG_OUTPUT_COUNT: output_count_reg <= cfg_data[3:0];
                REG_WEIGHT_LOW:   weight_low_reg   <= cfg_data;
                REG_WEIGHT_HIGH:  weight_high_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    ctrl_t ctrl;
    logic [$clog2(WEIGHT_DEPTH):0] waddr;
    logic [6:0] unit_idx, term_idx;
    logic ctl_busy;

    mlpsf_ctrl #(
        .MAX_INPUTS(MAX_INPUTS), .MAX_HIDDEN(MAX_HIDDEN),
        .MAX_OUTPUTS(MAX_OUTPUTS), .WEIGHT_DEPTH(WEIGHT_DEPTH)
    ) u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .cmd(cmd),
        .input_count(input_count_reg), .hidden_count(hidden_count_reg),
        .output_count(output_count_reg), .busy(ctl_busy), .ctrl(ctrl),
        .waddr(waddr), .unit_idx(unit_idx), .term_idx(term_idx)
    );

    assign busy = ctl_busy;

    mlpsf_dp #(
        .MAX_INPUTS(MAX_INPUTS), .MAX_HIDDEN(MAX_HIDDEN), .WEIGHT_DEPTH(WEIGHT_DEPTH)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .waddr(waddr),
        .unit_idx(unit_idx), .term_idx(term_idx),
        .weight_index(weight_index), .weight_byte(weight_byte), .sample(sample),
        .weight_low(weight_low_reg), .weight_high(weight_high_reg),
        .out_value(out_value), .out_index(out_index), .out_last(out_last),
        .done(done)
    );
endmodule

[rtl/mlpsf_ram.sv]
// ----------------------------------------------------------------------------
// mlpsf_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module mlpsf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

[rtl/mlpsf_ctrl.sv]
// ----------------------------------------------------------------------------
// mlpsf_ctrl
// Sequencer: weight scaling steps, sample buffering and the MAC walk.
// ----------------------------------------------------------------------------
module mlpsf_ctrl #(
    parameter int MAX_INPUTS   = 16,
    parameter int MAX_HIDDEN   = 16,
    parameter int MAX_OUTPUTS  = 8,
    parameter int WEIGHT_DEPTH = 512
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            cmd,
    input  logic [4:0]                      input_count,
    input  logic [4:0]                      hidden_count,
    input  logic [3:0]                      output_count,
    output logic                            busy,
    output mlpsf_pkg::ctrl_t                ctrl,
    output logic [$clog2(WEIGHT_DEPTH):0]   waddr,     // one extra bit: beyond store
    output logic [6:0]                      unit_idx,
    output logic [6:0]                      term_idx
);
    import mlpsf_pkg::*;

    localparam int AW = $clog2(WEIGHT_DEPTH) + 1;
    localparam int RW = 16;

    state_t state_reg, state_next;
    logic [6:0] pos_reg, pos_next;
    logic [6:0] unit_reg, unit_next;
    logic [6:0] term_reg, term_next;
    logic       layer_reg, layer_next;
    logic [RW-1:0] row_reg, row_next;
    logic [RW-1:0] raddr;

    logic [6:0] ni, nh, no, nterm, nunit;

    always_comb
    begin
        ni = (input_count == 5'd0) ? 7'd1 :
             (7'(input_count) > 7'(MAX_INPUTS)) ? 7'(MAX_INPUTS) : 7'(input_count);
        nh = (hidden_count == 5'd0) ? 7'd1 :
             (7'(hidden_count) > 7'(MAX_HIDDEN)) ? 7'(MAX_HIDDEN) : 7'(hidden_count);
        no = (output_count == 4'd0) ? 7'd1 :
             (7'(output_count) > 7'(MAX_OUTPUTS)) ? 7'(MAX_OUTPUTS) : 7'(output_count);
        nterm = layer_reg ? nh : ni;
        nunit = layer_reg ? no : nh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pos_reg   <= '0;
            unit_reg  <= '0;
            term_reg  <= '0;
            layer_reg <= 1'b0;
            row_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            unit_reg  <= unit_next;
            term_reg  <= term_next;
            layer_reg <= layer_next;
            row_reg   <= row_next;
        end
    end

    assign busy     = (state_reg != ST_IDLE);
    assign unit_idx = unit_reg;
    assign term_idx = (pos_reg >= 7'(MAX_INPUTS)) && (state_reg == ST_IDLE)
                      ? 7'(MAX_INPUTS - 1) : (state_reg == ST_IDLE ? pos_reg : term_reg);

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        unit_next  = unit_reg;
        term_next  = term_reg;
        layer_next = layer_reg;
        row_next   = row_reg;
        ctrl       = '0;
        ctrl.layer = layer_reg;
        raddr      = row_reg + RW'(term_reg);
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (cmd == CMD_LOAD)
                    begin
                        ctrl.load_mul = 1'b1;
                        state_next    = ST_LOAD_MUL;
                    end
                    else
                    begin
                        ctrl.sample_wr = 1'b1;
                        if (((pos_reg >= 7'(MAX_INPUTS)) ? 7'(MAX_INPUTS) : pos_reg + 7'd1)
                            < ni)
                        begin
                            pos_next = pos_reg + 7'd1;
                        end
                        else
                        begin
                            pos_next   = '0;
                            layer_next = 1'b0;
                            unit_next  = '0;
                            row_next   = '0;
                            state_next = ST_BIAS_RD;
                        end
                    end
                end
            end
            ST_LOAD_MUL:
            begin
                ctrl.load_div = 1'b1;
                state_next    = ST_LOAD_DIV;
            end
            ST_LOAD_DIV:
            begin
                state_next = ST_LOAD_WR;
            end
            ST_LOAD_WR:
            begin
                ctrl.load_wr = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_BIAS_RD:
            begin
                raddr      = row_reg + RW'(nterm);
                state_next = ST_BIAS_WAIT;
            end
            ST_BIAS_WAIT:
            begin
                ctrl.bias_load = 1'b1;
                term_next      = '0;
                state_next     = ST_MAC_RD;
            end
            ST_MAC_RD:
            begin
                state_next = ST_MAC_WAIT;
            end
            ST_MAC_WAIT:
            begin
                ctrl.mac_mul = 1'b1;
                state_next   = ST_MAC_MUL;
            end
            ST_MAC_MUL:
            begin
                state_next = ST_MAC_ACC;
            end
            ST_MAC_ACC:
            begin
                ctrl.mac_acc = 1'b1;
                if (term_reg + 7'd1 < nterm)
                begin
                    term_next  = term_reg + 7'd1;
                    state_next = ST_MAC_RD;
                end
                else
                begin
                    state_next = ST_SIG_A;
                end
            end
            ST_SIG_A:
            begin
                ctrl.sig_a = 1'b1;
                state_next = ST_SIG_B;
            end
            ST_SIG_B:
            begin
                ctrl.sig_b = 1'b1;
                state_next = ST_SIG_C;
            end
            ST_SIG_C:
            begin
                ctrl.sig_c = 1'b1;
                row_next   = row_reg + RW'(nterm) + RW'(1);
                term_next  = '0;
                if (!layer_reg)
                begin
                    ctrl.hid_wr = 1'b1;
                end
                else
                begin
                    ctrl.out_strobe = 1'b1;
                    ctrl.out_last   = (unit_reg + 7'd1 == nunit);
                end
                if (unit_reg + 7'd1 < nunit)
                begin
                    unit_next  = unit_reg + 7'd1;
                    state_next = ST_BIAS_RD;
                end
                else if (!layer_reg)
                begin
                    unit_next  = '0;
                    layer_next = 1'b1;
                    state_next = ST_BIAS_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        // flag any address past the store so the read answers zero
        waddr = (raddr >= RW'(WEIGHT_DEPTH)) ? {1'b1, (AW-1)'(0)}
                                             : {1'b0, raddr[AW-2:0]};
    end

    property p_strobe_in_output_layer;
        @(posedge clk) disable iff (!rst_n) ctrl.out_strobe |-> layer_reg;
    endproperty
    a_strobe_layer: assert property (p_strobe_in_output_layer)
        else $error("result strobe outside output layer");

    property p_idle_after_last;
        @(posedge clk) disable iff (!rst_n) ctrl.out_last |=> (state_reg == ST_IDLE);
    endproperty
    a_idle_after_last: assert property (p_idle_after_last)
        else $error("pass did not end after last result");

    property p_term_bound;
        @(posedge clk) disable iff (!rst_n) ctrl.mac_acc |-> (term_reg < nterm);
    endproperty
    a_term_bound: assert property (p_term_bound)
        else $error("term index past row length");
endmodule

[rtl/mlpsf_dp.sv]
// ----------------------------------------------------------------------------
// mlpsf_dp
// Datapath: weight scaling, weight RAM, buffers, MAC, saturation and sigmoid.
// ----------------------------------------------------------------------------
module mlpsf_dp #(
    parameter int MAX_INPUTS   = 16,
    parameter int MAX_HIDDEN   = 16,
    parameter int WEIGHT_DEPTH = 512
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mlpsf_pkg::ctrl_t              ctrl,
    input  logic [$clog2(WEIGHT_DEPTH):0] waddr,
    input  logic [6:0]                    unit_idx,
    input  logic [6:0]                    term_idx,
    input  logic [8:0]                    weight_index,
    input  logic [7:0]                    weight_byte,
    input  logic [15:0]                   sample,
    input  logic signed [15:0]            weight_low,
    input  logic signed [15:0]            weight_high,
    output logic [15:0]                   out_value,
    output logic [2:0]                    out_index,
    output logic                          out_last,
    output logic                          done
);
    import mlpsf_pkg::*;

    localparam int AW  = $clog2(WEIGHT_DEPTH);
    localparam int IW  = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
    localparam int HW  = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1;
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // weight load: scale, round to nearest by 255
    logic [AW:0]          load_addr_reg;
    logic signed [25:0]   num_reg;
    logic signed [15:0]   wval_reg;
    logic [25:0]          mag;
    logic [25:0]          qmag;
    logic [57:0]          recip;

    always_comb
    begin
        mag   = num_reg[25] ? 26'(-num_reg) : 26'(num_reg);
        recip = 58'(mag + 26'd127) * 58'd16843010;   // ~2^32/255, exact below 2^24
        qmag  = recip[32 +: 26];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_mul)
        begin
            num_reg       <= 26'($signed({1'b0, weight_byte}) *
                                 (26'(weight_high) - 26'(weight_low)));
            load_addr_reg <= (32'(weight_index) >= WEIGHT_DEPTH) ? {1'b1, AW'(0)}
                                                                 : {1'b0, AW'(weight_index)};
        end
        if (ctrl.load_div)
        begin
            wval_reg <= 16'(weight_low + (num_reg[25] ? -$signed(qmag) : $signed(qmag)));
        end
    end

    logic ram_we;
    logic [AW-1:0] ram_addr;
    logic [15:0] ram_rdata;
    logic beyond_reg;
    logic signed [15:0] wrd;

    assign ram_we   = ctrl.load_wr && !load_addr_reg[AW];
    assign ram_addr = ctrl.load_wr ? load_addr_reg[AW-1:0] : waddr[AW-1:0];

    mlpsf_ram #(.WIDTH(16), .DEPTH(WEIGHT_DEPTH)) u_wram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (wval_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        beyond_reg <= waddr[AW];
    end
    assign wrd = beyond_reg ? 16'sd0 : $signed(ram_rdata);

    // buffers, each read at one controller index
    logic [15:0] samp_mem [MAX_INPUTS];
    logic [15:0] hid_mem  [MAX_HIDDEN];
    logic [15:0] val_reg;

    logic [16:0]             sig_reg;
    always_ff @(posedge clk)
    begin
        if (ctrl.sample_wr)
        begin
            samp_mem[term_idx[IW-1:0]] <= sample;
        end
        if (ctrl.hid_wr)
        begin
            hid_mem[unit_idx[HW-1:0]] <= sig_reg[15:0];
        end
        val_reg <= ctrl.layer ? hid_mem[term_idx[HW-1:0]] : samp_mem[term_idx[IW-1:0]];
    end

    // MAC
    logic signed [32:0]      prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W:0]   sum;

    assign sum = ACC_W'(acc_reg) + (ACC_W+1)'(prod_reg);

    always_ff @(posedge clk)
    begin
        if (ctrl.mac_mul)
        begin
            prod_reg <= wrd * $signed({1'b0, val_reg});
        end
        if (ctrl.bias_load)
        begin
            acc_reg <= ACC_W'($signed({wrd, 16'h0000}));
        end
        else if (ctrl.mac_acc)
        begin
            if (sum > (ACC_W+1)'(ACC_MAX))
                acc_reg <= ACC_MAX;
            else if (sum < (ACC_W+1)'(ACC_MIN))
                acc_reg <= ACC_MIN;
            else
                acc_reg <= sum[ACC_W-1:0];
        end
    end

    // sigmoid: clamp, table pair, interpolate
    logic [5:0]  sidx_reg;
    logic [22:0] frac_reg;
    logic        sat_hi_reg, sat_lo_reg;
    logic [15:0] base_reg, diff_reg;
    logic [38:0] interp;
    logic signed [ACC_W-1:0] off;

    assign off = acc_reg + ACC_W'(29'sd134217728);

    always_ff @(posedge clk)
    begin
        if (ctrl.sig_a)
        begin
            sat_hi_reg <= acc_reg >= ACC_W'(29'sd134217728);
            sat_lo_reg <= acc_reg <= -ACC_W'(29'sd134217728);
            sidx_reg   <= {1'b0, off[27:23]};
            frac_reg   <= off[22:0];
        end
        if (ctrl.sig_b)
        begin
            base_reg <= sat_hi_reg ? sig_lut(6'd32) : sat_lo_reg ? sig_lut(6'd0)
                        : sig_lut(sidx_reg);
            diff_reg <= (sat_hi_reg || sat_lo_reg) ? 16'd0
                        : sig_lut(sidx_reg + 6'd1) - sig_lut(sidx_reg);
        end
    end

    assign interp = 39'(diff_reg) * 39'(frac_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done <= 1'b0;
        end
        else
        begin
            done <= ctrl.out_strobe;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.sig_c || ctrl.out_strobe)
        begin
            out_index <= unit_idx[2:0];
            out_last  <= ctrl.out_last;
        end
    end

    assign sig_reg   = 17'(base_reg) + 17'(interp[38:23]);
    assign out_value = sig_reg[15:0];

    a_no_load_during_pass: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load_wr |-> !ctrl.mac_acc)
        else $error("weight write during accumulation");
endmodule
